FILE: src/gbn_pkg.sv
// Shared constants, codes and control/status structs for the Go-Back-N sender.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

  localparam int WINDOW_MAX = 32;

  localparam int SEQ_W     = 32;
  localparam int TICK_W    = 16;
  localparam int WSIZE_W   = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int FUNC_W    = 2;
  localparam int PTYPE_W   = 2;
  localparam int KIND_W    = 2;
  localparam int PHASE_W   = 3;

  localparam logic [WSIZE_W-1:0] WSIZE_RESET   = WSIZE_W'(1);
  localparam logic [TICK_W-1:0]  TIMEOUT_RESET = TICK_W'(500);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SEQUENCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 2'd3;

  // Event kinds on the input channel.
  localparam logic [FUNC_W-1:0] FUNC_BEGIN  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_HEADER = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

  // Packet types.
  localparam logic [PTYPE_W-1:0] PKT_START = 2'd0;
  localparam logic [PTYPE_W-1:0] PKT_END   = 2'd1;
  localparam logic [PTYPE_W-1:0] PKT_DATA  = 2'd2;
  localparam logic [PTYPE_W-1:0] PKT_ACK   = 2'd3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd3;

  // Transfer phases.
  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_START = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DATA  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_END   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE  = 3'd4;

  // Source of the sequence number of an outgoing result.
  localparam logic [1:0] SEL_START = 2'd0;
  localparam logic [1:0] SEL_ZERO  = 2'd1;
  localparam logic [1:0] SEL_NEXT  = 2'd2;
  localparam logic [1:0] SEL_CUR   = 2'd3;

  typedef struct packed {
    logic              latch_in;
    logic              clr_ptr;
    logic              set_base;
    logic              adv;
    logic              tmr_clr;
    logic              tmr_inc;
    logic              cur_load;
    logic              cur_inc;
    logic              next_inc;
    logic              out_load;
    logic [KIND_W-1:0] out_kind;
    logic [1:0]        out_sel;
    logic              out_last;
  } gbn_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              seq_match;
    logic              ack_ahead;
    logic              timeout;
    logic              outstanding;
    logic              can_send;
    logic              can_send_nxt;
    logic              end_due;
    logic              cur_last;
    logic              slot_free;
  } gbn_sts_t;

endpackage

`default_nettype wire

FILE: src/gbn_if.sv
// Valid/ready channel interfaces for the sender's event input and packet output.
// Depends on gbn_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface gbn_in_if;
  import gbn_pkg::*;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [PTYPE_W-1:0] rx_type;
  logic [SEQ_W-1:0]   rx_sequence;
  modport source(output valid, output func, output rx_type, output rx_sequence, input ready);
  modport sink(input valid, input func, input rx_type, input rx_sequence, output ready);
endinterface

interface gbn_out_if;
  import gbn_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [SEQ_W-1:0]  send_sequence;
  logic              last_of_run;
  modport source(output valid, output event_kind, output send_sequence, output last_of_run,
                 input ready);
  modport sink(input valid, input event_kind, input send_sequence, input last_of_run,
               output ready);
endinterface

`default_nettype wire

FILE: src/gbn_datapath.sv
// Datapath of the sender: configuration registers, window pointers, tick timer,
// resend cursor and the output register. Depends on gbn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbn_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [gbn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gbn_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic [gbn_pkg::FUNC_W-1:0]   in_func,
  input  wire logic [gbn_pkg::PTYPE_W-1:0]  in_rx_type,
  input  wire logic [gbn_pkg::SEQ_W-1:0]    in_rx_sequence,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic [gbn_pkg::KIND_W-1:0]        out_event_kind,
  output logic [gbn_pkg::SEQ_W-1:0]         out_send_sequence,
  output logic                              out_last_of_run,
  input  wire gbn_pkg::gbn_cmd_t            cmd,
  output gbn_pkg::gbn_sts_t                 sts
);
  import gbn_pkg::*;

  logic [WSIZE_W-1:0] wsize_r;
  logic [SEQ_W-1:0]   total_r;
  logic [SEQ_W-1:0]   start_seq_r;
  logic [TICK_W-1:0]  tmo_r;

  logic [FUNC_W-1:0]  func_r;
  logic [PTYPE_W-1:0] rx_type_r;
  logic [SEQ_W-1:0]   rx_seq_r;

  logic [SEQ_W-1:0]   base_r;
  logic [SEQ_W-1:0]   next_r;
  logic [TICK_W-1:0]  tick_r;
  logic [SEQ_W:0]     lim_r;
  logic [SEQ_W-1:0]   cur_r;

  logic               out_valid_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic [SEQ_W-1:0]   out_seq_r;
  logic               out_last_r;

  logic [SEQ_W:0]     eff_win;
  logic [SEQ_W:0]     wsize_ext;
  logic [TICK_W-1:0]  tick_limit;
  logic [TICK_W-1:0]  tick_inc;
  logic [SEQ_W-1:0]   new_base;
  logic [SEQ_W:0]     next_ext;
  logic [SEQ_W:0]     next_p1;
  logic [SEQ_W:0]     total_ext;
  logic [SEQ_W-1:0]   sel_seq;

  always_comb begin
    wsize_ext = (SEQ_W+1)'(wsize_r);
    if (wsize_r == '0) begin
      eff_win = (SEQ_W+1)'(1);
    end else if (wsize_ext > (SEQ_W+1)'(WINDOW_MAX)) begin
      eff_win = (SEQ_W+1)'(WINDOW_MAX);
    end else begin
      eff_win = wsize_ext;
    end
  end

  assign tick_limit = (tmo_r == '0) ? TICK_W'(1) : tmo_r;
  assign tick_inc   = (tick_r == '1) ? tick_r : tick_r + TICK_W'(1);
  assign new_base   = (rx_seq_r < total_r) ? rx_seq_r : total_r;
  assign next_ext   = {1'b0, next_r};
  assign next_p1    = next_ext + (SEQ_W+1)'(1);
  assign total_ext  = {1'b0, total_r};

  always_comb begin
    sts.func         = func_r;
    sts.seq_match    = (rx_type_r == PKT_ACK) && (rx_seq_r == start_seq_r);
    sts.ack_ahead    = (rx_type_r == PKT_ACK) && (rx_seq_r > base_r);
    sts.timeout      = tick_inc >= tick_limit;
    sts.outstanding  = base_r < next_r;
    sts.can_send     = (next_ext < total_ext) && (next_ext < lim_r);
    sts.can_send_nxt = (next_p1 < total_ext) && (next_p1 < lim_r);
    sts.end_due      = base_r >= total_r;
    sts.cur_last     = (cur_r + SEQ_W'(1)) == next_r;
    sts.slot_free    = !out_valid_r || out_ready;
  end

  always_comb begin
    case (cmd.out_sel)
      SEL_START: sel_seq = start_seq_r;
      SEL_ZERO:  sel_seq = '0;
      SEL_NEXT:  sel_seq = next_r;
      SEL_CUR:   sel_seq = cur_r;
      default:   sel_seq = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r     <= WSIZE_RESET;
      total_r     <= '0;
      start_seq_r <= '0;
      tmo_r       <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_SIZE:    wsize_r     <= cfg_wdata[WSIZE_W-1:0];
        CFG_TOTAL_PACKETS:  total_r     <= cfg_wdata[SEQ_W-1:0];
        CFG_START_SEQUENCE: start_seq_r <= cfg_wdata[SEQ_W-1:0];
        CFG_TIMEOUT_TICKS:  tmo_r       <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      next_r      <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_ptr) begin
        base_r <= '0;
      end else if (cmd.set_base) begin
        base_r <= new_base;
      end
      if (cmd.clr_ptr) begin
        next_r <= '0;
      end else if (cmd.adv) begin
        next_r <= (next_r < base_r) ? base_r : next_r;
      end else if (cmd.next_inc) begin
        next_r <= next_r + SEQ_W'(1);
      end
      if (cmd.tmr_clr || cmd.adv) begin
        tick_r <= '0;
      end else if (cmd.tmr_inc) begin
        tick_r <= tick_inc;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      func_r    <= in_func;
      rx_type_r <= in_rx_type;
      rx_seq_r  <= in_rx_sequence;
    end
    if (cmd.adv) begin
      lim_r <= {1'b0, base_r} + eff_win;
    end
    if (cmd.cur_load) begin
      cur_r <= base_r;
    end else if (cmd.cur_inc) begin
      cur_r <= cur_r + SEQ_W'(1);
    end
    if (cmd.out_load) begin
      out_kind_r <= cmd.out_kind;
      out_seq_r  <= sel_seq;
      out_last_r <= cmd.out_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_kind_r;
  assign out_send_sequence = out_seq_r;
  assign out_last_of_run   = out_last_r;

endmodule

`default_nettype wire

FILE: src/gbn_ctrl.sv
// Controller of the sender: transfer phase and the sequencer that decodes an
// event and steps out its packets. Depends on gbn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbn_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire gbn_pkg::gbn_sts_t sts,
  output gbn_pkg::gbn_cmd_t      cmd
);
  import gbn_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_EMIT   = 3'd2;
  localparam logic [2:0] ST_ADV    = 3'd3;
  localparam logic [2:0] ST_FILL   = 3'd4;
  localparam logic [2:0] ST_RESEND = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_IDLE;
        case (sts.func)
          FUNC_BEGIN: begin
            if (phase_r == PH_IDLE || phase_r == PH_DONE) begin
              phase_nxt   = PH_START;
              cmd.clr_ptr = 1'b1;
              cmd.tmr_clr = 1'b1;
              kind_nxt    = KIND_START;
              state_nxt   = ST_EMIT;
            end
          end
          FUNC_HEADER: begin
            case (phase_r)
              PH_START: begin
                if (sts.seq_match) begin
                  phase_nxt   = PH_DATA;
                  cmd.clr_ptr = 1'b1;
                  state_nxt   = ST_ADV;
                end else begin
                  cmd.tmr_clr = 1'b1;
                  kind_nxt    = KIND_START;
                  state_nxt   = ST_EMIT;
                end
              end
              PH_DATA: begin
                if (sts.ack_ahead) begin
                  cmd.set_base = 1'b1;
                  state_nxt    = ST_ADV;
                end
              end
              PH_END: begin
                if (sts.seq_match) begin
                  phase_nxt = PH_DONE;
                  kind_nxt  = KIND_DONE;
                end else begin
                  cmd.tmr_clr = 1'b1;
                  kind_nxt    = KIND_END;
                end
                state_nxt = ST_EMIT;
              end
              default: ;
            endcase
          end
          FUNC_TICK: begin
            if (phase_r == PH_START || phase_r == PH_DATA || phase_r == PH_END) begin
              if (!sts.timeout) begin
                cmd.tmr_inc = 1'b1;
              end else if (phase_r == PH_DATA) begin
                if (sts.outstanding) begin
                  cmd.tmr_clr  = 1'b1;
                  cmd.cur_load = 1'b1;
                  state_nxt    = ST_RESEND;
                end else begin
                  cmd.tmr_inc = 1'b1;
                end
              end else begin
                cmd.tmr_clr = 1'b1;
                kind_nxt    = (phase_r == PH_START) ? KIND_START : KIND_END;
                state_nxt   = ST_EMIT;
              end
            end
          end
          default: ;
        endcase
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = kind_r;
          cmd.out_sel  = (kind_r == KIND_DONE) ? SEL_ZERO : SEL_START;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_ADV: begin
        cmd.adv   = 1'b1;
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (sts.can_send) begin
          if (sts.slot_free) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = KIND_DATA;
            cmd.out_sel  = SEL_NEXT;
            cmd.out_last = !sts.can_send_nxt && !sts.end_due;
            cmd.next_inc = 1'b1;
            if (!sts.can_send_nxt) begin
              if (sts.end_due) begin
                phase_nxt = PH_END;
                kind_nxt  = KIND_END;
                state_nxt = ST_EMIT;
              end else begin
                state_nxt = ST_IDLE;
              end
            end
          end
        end else if (sts.end_due) begin
          phase_nxt = PH_END;
          kind_nxt  = KIND_END;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RESEND: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_DATA;
          cmd.out_sel  = SEL_CUR;
          cmd.out_last = sts.cur_last;
          cmd.cur_inc  = 1'b1;
          if (sts.cur_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_IDLE;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
  end

endmodule

`default_nettype wire

FILE: src/go_back_n_sender.sv
// Top level of the Go-Back-N sender: controller plus datapath behind two
// valid/ready channels and a configuration write port. Depends on gbn_pkg, gbn_if, gbn_ctrl, gbn_datapath.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one event item at a time (begin transfer, received header or
// timer tick) and answers with the packets to send, one result item per cycle
// from an output register while the output side takes every item, the final one
// flagged by last_of_run. An event that causes no packet ends after its decode
// step; one that sends a single START, END or completion goes on to an emit step;
// an ACK that refills the window goes through an advance step and a fill step
// that sends the DATA packets, followed by an emit step for an END that closes
// the transfer; a data timeout goes on to a resend step for the outstanding
// packets from window base up to next-to-send. The sequencer in the controller
// emits at most one packet per cycle and stalls whenever the output register is
// full and its item is not taken. The next event is accepted as soon as the
// sequencer is back in its idle state, even if the last result still waits in
// the output register. Configuration registers may only be written while no
// event is in progress.

module go_back_n_sender (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [gbn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gbn_pkg::CFG_W-1:0]     cfg_wdata,
  gbn_in_if.sink                             in_ch,
  gbn_out_if.source                          out_ch
);
  import gbn_pkg::*;

  gbn_cmd_t cmd;
  gbn_sts_t sts;

  // Controller: owns the transfer phase and steps through each event.
  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: pointers, timer, configuration and the output register.
  gbn_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_func           (in_ch.func),
    .in_rx_type        (in_ch.rx_type),
    .in_rx_sequence    (in_ch.rx_sequence),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_event_kind    (out_ch.event_kind),
    .out_send_sequence (out_ch.send_sequence),
    .out_last_of_run   (out_ch.last_of_run),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule

`default_nettype wire
